FILE: rtl/gskl_pkg.sv
// Shared constants and the gain table of the soft knee limiter
`timescale 1ns / 1ps
package gskl_pkg;

	// sample width default and fixed field widths
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int GAIN_DB_W       = 5;
	localparam int GAIN_W          = 16;
	localparam int GAIN_DB_MAX     = 24;
	localparam int FRAC_BITS       = 12;

	// knee and span of the soft limiter, integer and Q.12
	localparam int KNEE_INT = 24000;
	localparam int SPAN_INT = 8767;
	localparam logic [63:0] KNEE_Q = 64'(KNEE_INT) << FRAC_BITS;
	localparam logic [63:0] SPAN_Q = 64'(SPAN_INT) << FRAC_BITS;
	localparam logic [63:0] KNEE_LESS_SPAN = KNEE_Q - SPAN_Q;

	// divider: constant dividend span^2, quotient always below 2^26
	localparam int QUO_BITS = 26;
	localparam logic [63:0] DIV_NUM  = SPAN_Q * SPAN_Q;
	localparam logic [63:0] DIV_INIT = DIV_NUM >> QUO_BITS;

	// width of the limited magnitude (always below 32767)
	localparam int LIM_W = 15;

	// linear gain in unsigned Q4.12, 10^(db/20); codes past the top saturate
	function automatic logic [GAIN_W-1:0] gain_lut(input logic [GAIN_DB_W-1:0] db);
		logic [GAIN_W-1:0] g;
		unique case (db)
			5'd0:    g = 16'd4096;
			5'd1:    g = 16'd4596;
			5'd2:    g = 16'd5157;
			5'd3:    g = 16'd5786;
			5'd4:    g = 16'd6492;
			5'd5:    g = 16'd7284;
			5'd6:    g = 16'd8173;
			5'd7:    g = 16'd9170;
			5'd8:    g = 16'd10289;
			5'd9:    g = 16'd11544;
			5'd10:   g = 16'd12953;
			5'd11:   g = 16'd14533;
			5'd12:   g = 16'd16306;
			5'd13:   g = 16'd18296;
			5'd14:   g = 16'd20529;
			5'd15:   g = 16'd23034;
			5'd16:   g = 16'd25844;
			5'd17:   g = 16'd28997;
			5'd18:   g = 16'd32536;
			5'd19:   g = 16'd36506;
			5'd20:   g = 16'd40960;
			5'd21:   g = 16'd45958;
			5'd22:   g = 16'd51566;
			5'd23:   g = 16'd57858;
			default: g = 16'd64917;
		endcase
		return g;
	endfunction

endpackage

FILE: rtl/gskl_front.sv
// Front stages: sign split, gain multiply, knee test and divisor setup
`timescale 1ns / 1ps
module gskl_front #(
	parameter int SB     = 16,
	parameter int DW     = 33,
	parameter int SIDE_W = 39
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gskl_pkg::GAIN_DB_W-1:0] gain_db,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SB-1:0]          sample_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [DW-1:0]                 den,
	output logic [SIDE_W-1:0]             side
);
	import gskl_pkg::*;

	localparam int MB    = SB + GAIN_W;
	localparam int LIN_W = MB - FRAC_BITS;

	logic              v_s1, v_s2, v_s3;
	logic              rdy_s1, rdy_s2, rdy_s3;
	logic              pass_s1, pass_s2, pass_s3;
	logic              neg_s1, neg_s2, neg_s3;
	logic [SB-1:0]     raw_s1, raw_s2, raw_s3;
	logic [SB-1:0]     mag_s1;
	logic [GAIN_W-1:0] gain_s1;
	logic [MB-1:0]     prod_s2;
	logic              over_s3;
	logic [DW-1:0]     den_s3;
	logic [LIN_W-1:0]  lin_s3;
	logic [SB-1:0]     raw_in;
	logic [DW-1:0]     prod_ext;

	// stage enables, a stage loads when empty or when its successor moves
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign raw_in   = sample_in;
	assign prod_ext = DW'(prod_s2);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: magnitude and sign, gain lookup
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pass_s1 <= (gain_db == '0);
			neg_s1  <= raw_in[SB-1];
			raw_s1  <= raw_in;
			mag_s1  <= raw_in[SB-1] ? (~raw_in + SB'(1)) : raw_in;
			gain_s1 <= gain_lut(gain_db);
		end
	end

	// stage 2: magnitude times gain, Q.12
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			pass_s2 <= pass_s1;
			neg_s2  <= neg_s1;
			raw_s2  <= raw_s1;
			prod_s2 <= {{GAIN_W{1'b0}}, mag_s1} * {{SB{1'b0}}, gain_s1};
		end
	end

	// stage 3: knee compare and divisor span + excess
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			pass_s3 <= pass_s2;
			neg_s3  <= neg_s2;
			raw_s3  <= raw_s2;
			over_s3 <= prod_ext > DW'(KNEE_Q);
			den_s3  <= prod_ext - DW'(KNEE_LESS_SPAN);
			lin_s3  <= prod_s2[MB-1:FRAC_BITS];
		end
	end

	// side word: pass, neg, over, raw sample, linear magnitude
	assign out_valid = v_s3;
	assign den       = den_s3;
	assign side      = {pass_s3, neg_s3, over_s3, raw_s3, lin_s3};

endmodule

FILE: rtl/gskl_div_cell.sv
// One divider cell: a single restoring step on a constant dividend bit
`timescale 1ns / 1ps
module gskl_div_cell #(
	parameter int   DW      = 33,
	parameter int   QB      = 26,
	parameter int   SIDE_W  = 39,
	parameter logic NUM_BIT = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DW-1:0]     rem_in,
	input  logic [QB-1:0]     quo_in,
	input  logic [DW-1:0]     den_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DW-1:0]     rem_out,
	output logic [QB-1:0]     quo_out,
	output logic [DW-1:0]     den_out,
	output logic [SIDE_W-1:0] side_out
);

	logic              valid_q;
	logic [DW-1:0]     rem_q;
	logic [QB-1:0]     quo_q;
	logic [DW-1:0]     den_q;
	logic [SIDE_W-1:0] side_q;
	logic [DW:0]       shifted;
	logic [DW:0]       diff;
	logic              ge;

	// shift in the next dividend bit and try the subtract
	assign shifted  = {rem_in, NUM_BIT};
	assign ge       = shifted >= {1'b0, den_in};
	assign diff     = shifted - {1'b0, den_in};
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// remainder, quotient bit and passenger data move one cell on
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_q  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q  <= {quo_in[QB-2:0], ge};
			den_q  <= den_in;
			side_q <= side_in;
		end
	end

	assign out_valid = valid_q;
	assign rem_out   = rem_q;
	assign quo_out   = quo_q;
	assign den_out   = den_q;
	assign side_out  = side_q;

endmodule

FILE: rtl/gskl_back.sv
// Back stages: limited magnitude from the quotient, sign restore, output register
`timescale 1ns / 1ps
module gskl_back #(
	parameter int SB     = 16,
	parameter int DW     = 33,
	parameter int QB     = 26,
	parameter int SIDE_W = 39
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DW-1:0]        rem,
	input  logic [QB-1:0]        quo,
	input  logic [SIDE_W-1:0]    side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [SB-1:0] sample_out
);
	import gskl_pkg::*;

	localparam int MB    = SB + GAIN_W;
	localparam int LIN_W = MB - FRAC_BITS;
	localparam int MAG_W = (LIN_W > LIM_W) ? LIN_W : LIM_W;

	logic             v_s1, v_s2;
	logic             rdy_s1, rdy_s2;
	logic             pass_in, neg_in, over_in;
	logic [SB-1:0]    raw_in;
	logic [LIN_W-1:0] lin_in;
	logic [QB-1:0]    ceil_q;
	logic [QB-1:0]    frac_part;
	logic [LIM_W-1:0] lim;
	logic             pass_s1, neg_s1;
	logic [SB-1:0]    raw_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [MAG_W-1:0] mag_neg;
	logic [SB-1:0]    res_s2;

	// unpack the side word
	assign lin_in  = side[LIN_W-1:0];
	assign raw_in  = side[LIN_W+SB-1:LIN_W];
	assign over_in = side[LIN_W+SB];
	assign neg_in  = side[LIN_W+SB+1];
	assign pass_in = side[LIN_W+SB+2];

	// knee + (span - ceil(span^2 / den)), then drop the fraction
	assign ceil_q    = quo + QB'(rem != '0);
	assign frac_part = SPAN_Q[QB-1:0] - ceil_q;
	assign lim       = LIM_W'(KNEE_INT) + LIM_W'(frac_part >> FRAC_BITS);

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	// stage 1: pick linear or limited magnitude
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pass_s1 <= pass_in;
			neg_s1  <= neg_in;
			raw_s1  <= raw_in;
			mag_s1  <= over_in ? MAG_W'(lim) : MAG_W'(lin_in);
		end
	end

	assign mag_neg = ~mag_s1 + MAG_W'(1);

	// stage 2: output register, sign restored or the sample passed through
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			if (pass_s1) begin
				res_s2 <= raw_s1;
			end else if (neg_s1) begin
				res_s2 <= mag_neg[SB-1:0];
			end else begin
				res_s2 <= mag_s1[SB-1:0];
			end
		end
	end

	assign out_valid  = v_s2;
	assign sample_out = res_s2;

endmodule

FILE: rtl/gain_soft_knee_limiter_unit.sv
// Top level of the gain and soft knee limiter
// Applies a dB gain (0..24, codes above 24 act as 24, 0 passes samples through untouched)
// to signed samples and limits magnitudes above 24000 with a smooth knee that stays
// below 32767. One item is accepted per cycle while no stall holds the input. Each item
// passes through three front stages (sign split, multiply, knee test), then a row
// of 26 divider cells that each resolve one quotient bit of span^2 / (span + excess), and
// two back stages ending in the output register. Stages with an empty slot keep moving
// while the output is stalled. gain_db is written through cfg_wr_en / cfg_wr_data and
// resets to 0; it should change only while no item is in flight. No memory, no init pass.
`timescale 1ns / 1ps
module gain_soft_knee_limiter_unit #(
	parameter int SAMPLE_BITS = gskl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gskl_pkg::GAIN_DB_W-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	import gskl_pkg::*;

	localparam int MB       = SAMPLE_BITS + GAIN_W;
	localparam int DW       = (MB > 27) ? MB : 27;
	localparam int LIN_W    = MB - FRAC_BITS;
	localparam int SIDE_W   = 3 + SAMPLE_BITS + LIN_W;
	localparam int OVER_POS = LIN_W + SAMPLE_BITS;
	localparam int QB       = QUO_BITS;

	logic [GAIN_DB_W-1:0] gain_db_q;
	logic                 front_ready;
	logic                 back_ready;

	logic              valid_c [0:QB];
	logic              ready_c [0:QB];
	logic [DW-1:0]     rem_c   [0:QB];
	logic [QB-1:0]     quo_c   [0:QB];
	logic [DW-1:0]     den_c   [0:QB];
	logic [SIDE_W-1:0] side_c  [0:QB];

	// gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_db_q <= '0;
		end else if (cfg_wr_en) begin
			gain_db_q <= cfg_wr_data;
		end
	end

	assign in_stall = !front_ready;

	gskl_front #(
		.SB     (SAMPLE_BITS),
		.DW     (DW),
		.SIDE_W (SIDE_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain_db   (gain_db_q),
		.in_valid  (in_valid),
		.in_ready  (front_ready),
		.sample_in (sample_in),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.den       (den_c[0]),
		.side      (side_c[0])
	);

	// the divider starts from the top dividend bits, always below the divisor
	assign rem_c[0] = DW'(DIV_INIT);
	assign quo_c[0] = '0;

	// row of divider cells, one quotient bit each
	for (genvar k = 0; k < QB; k++) begin : g_cell
		gskl_div_cell #(
			.DW      (DW),
			.QB      (QB),
			.SIDE_W  (SIDE_W),
			.NUM_BIT (DIV_NUM[QB-1-k])
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[k]),
			.in_ready  (ready_c[k]),
			.rem_in    (rem_c[k]),
			.quo_in    (quo_c[k]),
			.den_in    (den_c[k]),
			.side_in   (side_c[k]),
			.out_valid (valid_c[k+1]),
			.out_ready (ready_c[k+1]),
			.rem_out   (rem_c[k+1]),
			.quo_out   (quo_c[k+1]),
			.den_out   (den_c[k+1]),
			.side_out  (side_c[k+1])
		);
	end

	assign ready_c[QB] = back_ready;

	gskl_back #(
		.SB     (SAMPLE_BITS),
		.DW     (DW),
		.QB     (QB),
		.SIDE_W (SIDE_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_c[QB]),
		.in_ready   (back_ready),
		.rem        (rem_c[QB]),
		.quo        (quo_c[QB]),
		.side       (side_c[QB]),
		.out_valid  (out_valid),
		.out_ready  (!out_stall),
		.sample_out (sample_out)
	);

	// an empty output stage means every stage can move, so input is never held
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output stage empty");

	// above the knee the divisor exceeds the span
	a_den_above_span: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_c[0] && side_c[0][OVER_POS]) |-> (den_c[0] > DW'(SPAN_Q)))
		else $error("divisor not above span for an item over the knee");

	// restoring division leaves a remainder below the divisor
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_c[QB] && side_c[QB][OVER_POS]) |-> (rem_c[QB] < den_c[QB]))
		else $error("divider remainder not below divisor");

endmodule

FILE: verif/gain_soft_knee_limiter_unit_tb.sv
// Self-checking testbench for the gain and soft knee limiter unit
`timescale 1ns / 1ps
module gain_soft_knee_limiter_unit_tb;
	import gskl_pkg::*;

	localparam int SW = 16;
	localparam int GAIN_TOP = 24;
	localparam int Q_BITS = 12;
	localparam logic [63:0] KNEE_MAG = 64'd24000 << Q_BITS;
	localparam logic [63:0] SPAN_MAG = 64'd8767 << Q_BITS;

	typedef struct packed {
		logic signed [SW-1:0] stim;
		logic signed [SW-1:0] want;
	} sample_pair_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [GAIN_DB_W-1:0] cfg_wr_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [SW-1:0] sample_out;

	sample_pair_t         expected_samples[$];
	sample_pair_t         head;
	logic [GAIN_DB_W-1:0] gain_db_model = '0;
	int                   mismatch_count = 0;
	bit                   idle_on = 1'b0;
	bit                   stall_on = 1'b0;

	gain_soft_knee_limiter_unit #(.SAMPLE_BITS(SW)) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	always #1 clk = ~clk;

	// linear gain in unsigned Q4.12, round(4096 * 10^(db/20))
	function automatic logic [63:0] linear_gain(input logic [GAIN_DB_W-1:0] db);
		case (db)
			5'd0:    return 64'd4096;
			5'd1:    return 64'd4596;
			5'd2:    return 64'd5157;
			5'd3:    return 64'd5786;
			5'd4:    return 64'd6492;
			5'd5:    return 64'd7284;
			5'd6:    return 64'd8173;
			5'd7:    return 64'd9170;
			5'd8:    return 64'd10289;
			5'd9:    return 64'd11544;
			5'd10:   return 64'd12953;
			5'd11:   return 64'd14533;
			5'd12:   return 64'd16306;
			5'd13:   return 64'd18296;
			5'd14:   return 64'd20529;
			5'd15:   return 64'd23034;
			5'd16:   return 64'd25844;
			5'd17:   return 64'd28997;
			5'd18:   return 64'd32536;
			5'd19:   return 64'd36506;
			5'd20:   return 64'd40960;
			5'd21:   return 64'd45958;
			5'd22:   return 64'd51566;
			5'd23:   return 64'd57858;
			default: return 64'd64917;
		endcase
	endfunction

	function automatic logic [GAIN_DB_W-1:0] clamp_gain(input logic [GAIN_DB_W-1:0] db);
		return (db > GAIN_TOP) ? GAIN_DB_W'(GAIN_TOP) : db;
	endfunction

	// gain then soft knee on the magnitude, sign restored, truncated toward zero
	function automatic logic signed [SW-1:0] predict_limited_sample(
		input logic signed [SW-1:0] s, input logic [GAIN_DB_W-1:0] db);
		logic [GAIN_DB_W-1:0] eff;
		logic [63:0] raw, mag, prod, excess, den, round_up, lim;
		eff = clamp_gain(db);
		if (eff == 0) return s;
		raw = {{(64-SW){1'b0}}, s};
		mag = s[SW-1] ? ((64'd1 << SW) - raw) : raw;
		prod = mag * linear_gain(eff);
		if (prod <= KNEE_MAG) begin
			lim = prod >> Q_BITS;
		end else begin
			// exact floor(d*C/(C+d)) as C - ceil(C*C/(C+d))
			excess = prod - KNEE_MAG;
			den = SPAN_MAG + excess;
			round_up = (SPAN_MAG * SPAN_MAG + den - 64'd1) / den;
			lim = (KNEE_MAG + SPAN_MAG - round_up) >> Q_BITS;
		end
		return s[SW-1] ? SW'(-lim) : SW'(lim);
	endfunction

	function automatic int unsigned pick_gap(input bit enabled);
		return enabled ? $urandom_range(0, 11) : 0;
	endfunction

	// send one item, record its prediction at acceptance
	task automatic send_sample(input logic signed [SW-1:0] value);
		int unsigned gap;
		gap = pick_gap(idle_on);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (in_stall);
		expected_samples.push_back('{value, predict_limited_sample(value, gain_db_model)});
	endtask

	// gain write once the pipeline has drained
	task automatic write_gain(input logic [GAIN_DB_W-1:0] db);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= db;
		@(posedge clk);
		gain_db_model = db;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// random sample: full range, small, extremes, or close to the knee
	function automatic logic signed [SW-1:0] random_sample();
		int v;
		logic [63:0] thr;
		case ($urandom_range(0, 5))
			2: v = $urandom_range(0, 2047);
			3: v = 32767 - $urandom_range(0, 7);
			4: begin
				if (clamp_gain(gain_db_model) == 0) begin
					v = $urandom_range(0, 32767);
				end else begin
					thr = KNEE_MAG / linear_gain(clamp_gain(gain_db_model));
					v = int'(thr) + $urandom_range(0, 8) - 4;
				end
			end
			default: return SW'($urandom);
		endcase
		if ($urandom_range(0, 1)) begin
			if (v == 32767 && $urandom_range(0, 1)) return 16'sh8000;
			return SW'(-v);
		end
		return SW'(v);
	endfunction

	// reset value of the gain is zero: items pass through untouched
	task automatic test_passthrough();
		idle_on = 1'b0;
		stall_on = 1'b0;
		send_sample(16'sd0);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd32767);
		send_sample(16'sh8000);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
	endtask

	// top of the table and codes above it, which saturate
	task automatic test_gain_extremes();
		idle_on = 1'b1;
		stall_on = 1'b1;
		write_gain(5'd24);
		send_sample(16'sd32767);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		write_gain(5'd31);
		send_sample(16'sd32767);
		send_sample(16'sh8000);
		send_sample(16'sd12345);
	endtask

	// magnitudes just below and just above the knee
	task automatic test_knee();
		idle_on = 1'b0;
		stall_on = 1'b1;
		write_gain(5'd1);
		send_sample(16'sd21389);
		send_sample(16'sd21390);
		send_sample(-16'sd21389);
		send_sample(-16'sd21390);
		write_gain(5'd24);
		send_sample(16'sd1514);
		send_sample(-16'sd1515);
	endtask

	// segments of random items, each under its own gain and idling mix
	task automatic test_random_stream();
		int unsigned count;
		logic [GAIN_DB_W-1:0] db;
		for (int seg = 0; seg < 16; seg++) begin
			case (seg)
				0:       db = 5'd24;
				1:       db = 5'd31;
				2:       db = 5'd0;
				3:       db = 5'd1;
				default: db = GAIN_DB_W'($urandom_range(0, 31));
			endcase
			write_gain(db);
			idle_on = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			count = $urandom_range(80, 125);
			for (int unsigned i = 0; i < count; i++) begin
				if (i % 40 == 20) idle_on = ~idle_on;
				send_sample(random_sample());
			end
		end
	endtask

	// output stall: a random hold before each item
	initial begin
		int unsigned n;
		wait (arst_n);
		forever begin
			n = pick_gap(stall_on);
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each accepted item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected sample_out: expected none, actual %0d",
					$time, sample_out);
			end else begin
				head = expected_samples.pop_front();
				if (sample_out !== head.want) begin
					mismatch_count++;
					$display("%0t sample_out mismatch (in %0d): expected %0d, actual %0d",
						$time, head.stim, head.want, sample_out);
				end
			end
		end
	end

	// watchdog
	initial begin
		#1000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_passthrough();
		test_gain_extremes();
		test_knee();
		test_random_stream();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		// let any stray item come out of the pipeline
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
